// File: hw/rtl/triangle_normal_and_mirror_macros.svh
// ----------------------------------------------------------------------------
// Triangle normal and mirror: assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_NORMAL_AND_MIRROR_MACROS_SVH
`define TRIANGLE_NORMAL_AND_MIRROR_MACROS_SVH

// Same-cycle implication, ignored while in reset
`define TNM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tnm port check failed");

// Next-cycle implication, ignored while in reset
`define TNM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tnm port check failed");

// Next-cycle implication that also holds across reset
`define TNM_ASSERT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("tnm port check failed");

`endif

// File: hw/rtl/tnm_pkg.sv
// ----------------------------------------------------------------------------
// Triangle normal and mirror: package
// Widths, pipeline latencies, mirror axis codes and small helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tnm_pkg;

    localparam int COORD_W   = 16;
    localparam int NUM_VERT  = 9;
    localparam int EDGE_W    = 17;
    localparam int PROD_W    = 34;
    localparam int CROSS_W   = 35;
    localparam int MAG_W     = 34;
    localparam int LEAD_W    = 6;
    localparam int TOP_BIT   = 29;
    localparam int NORM_W    = TOP_BIT + 1;
    localparam int SQ_W      = 2 * NORM_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int REM_W     = ROOT_W + 3;
    localparam int UNIT_SH   = 14;
    localparam int QUOT_W    = UNIT_SH + 1;
    localparam int NUM_W     = NORM_W + UNIT_SH + 1;
    localparam int PART_W    = ROOT_W + 1;

    localparam int CROSS_LAT = 3;
    localparam int PREP_LAT  = 5;
    localparam int SQRT_LAT  = ROOT_W;
    localparam int DIV_LAT   = QUOT_W + 1;
    localparam int VERT_LAT  = CROSS_LAT + PREP_LAT + SQRT_LAT + DIV_LAT;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        AXIS_NONE = 2'd0,
        AXIS_X    = 2'd1,
        AXIS_Y    = 2'd2,
        AXIS_Z    = 2'd3
    } axis_t;

    // Flags carried beside the normalized magnitudes
    typedef struct packed {
        logic [2:0] sgn;
        logic       zero;
    } nrm_flags_t;

    // Negate with saturation of the most negative code
    function automatic coord_t neg_sat(input coord_t v);
        coord_t res;
        if (v == coord_t'(-32768)) begin
            res = coord_t'(32767);
        end else begin
            res = -v;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/triangle_normal_and_mirror.sv
// Throughput: one triangle per cycle unless the output stalls; the 31-stage square
// root pipeline and 16-stage dividers set the depth, every stage advances together.
// A stall on m_tready freezes all stages and drops s_tready until the output drains.
// Reset (aresetn low, synchronous) clears every valid bit; payload is not reset.
// ----------------------------------------------------------------------------
// Triangle normal and mirror: top level
// Unit face normal of a triangle in Q1.14 with optional single-axis mirror.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_normal_and_mirror
    import tnm_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
    input  wire logic [143:0] s_tdata,
    // mirror_axis
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out0_x .. out2_z, normal_x, normal_y, normal_z
    output logic [191:0]      m_tdata
);

    localparam int VBUS_W = NUM_VERT * COORD_W + 2;
    localparam int MBUS_W = 3 * NORM_W + $bits(nrm_flags_t);

    logic                      en;
    logic                      in_fire;
    coord_t                    vin   [NUM_VERT];
    coord_t                    vmir  [NUM_VERT];
    axis_t                     axis_in;
    logic [VBUS_W-1:0]         vbus_in, vbus_out;

    logic                      cross_valid;
    logic signed [CROSS_W-1:0] cross_c [3];
    logic                      prep_valid;
    logic [NORM_W-1:0]         prep_m [3];
    nrm_flags_t                prep_flags;
    logic [SUM_W-1:0]          prep_sum;
    logic [MBUS_W-1:0]         mbus_in, mbus_out;
    logic [NORM_W-1:0]         m_dly [3];
    nrm_flags_t                fl_dly, fl_end;
    logic                      sqrt_valid;
    logic [ROOT_W-1:0]         root;
    logic [2:0]                div_valid;
    logic [QUOT_W-1:0]         quot [3];

    axis_t                     axis_end;
    coord_t                    nrm_next [3];
    logic                      m_tvalid_reg;
    logic [191:0]              m_tdata_reg;

    // Whole pipe advances unless a result is held at the output
    assign en       = m_tready || !m_tvalid_reg;
    assign s_tready = en;
    assign in_fire  = s_tvalid && en;
    assign axis_in  = axis_t'(s_tuser);

    // Unpack and mirror the vertices
    always_comb begin
        for (int i = 0; i < NUM_VERT; i++) begin
            vin[i]  = coord_t'(s_tdata[i*COORD_W +: COORD_W]);
            vmir[i] = (axis_in == axis_t'(2'((i % 3) + 1))) ? neg_sat(vin[i]) : vin[i];
            vbus_in[i*COORD_W +: COORD_W] = vmir[i];
        end
        vbus_in[VBUS_W-1 -: 2] = axis_in;
    end

    tnm_delay #(.WIDTH(VBUS_W), .DEPTH(VERT_LAT)) u_vdly (
        .aclk (aclk),
        .en   (en),
        .din  (vbus_in),
        .dout (vbus_out)
    );

    tnm_cross u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_fire),
        .v         (vin),
        .out_valid (cross_valid),
        .c         (cross_c)
    );

    tnm_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cross_valid),
        .c         (cross_c),
        .out_valid (prep_valid),
        .m         (prep_m),
        .flags     (prep_flags),
        .sum       (prep_sum)
    );

    tnm_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (prep_valid),
        .s         (prep_sum),
        .out_valid (sqrt_valid),
        .root      (root)
    );

    // Hold magnitudes and flags beside the root computation
    assign mbus_in = {prep_flags, prep_m[2], prep_m[1], prep_m[0]};

    tnm_delay #(.WIDTH(MBUS_W), .DEPTH(SQRT_LAT)) u_mdly (
        .aclk (aclk),
        .en   (en),
        .din  (mbus_in),
        .dout (mbus_out)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            m_dly[k] = mbus_out[k*NORM_W +: NORM_W];
        end
        fl_dly = nrm_flags_t'(mbus_out[MBUS_W-1 -: $bits(nrm_flags_t)]);
    end

    for (genvar k = 0; k < 3; k++) begin : g_div
        tnm_div u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sqrt_valid),
            .m         (m_dly[k]),
            .r         (root),
            .out_valid (div_valid[k]),
            .q         (quot[k])
        );
    end

    tnm_delay #(.WIDTH($bits(nrm_flags_t)), .DEPTH(DIV_LAT)) u_fdly (
        .aclk (aclk),
        .en   (en),
        .din  (fl_dly),
        .dout (fl_end)
    );

    // Restore signs, apply the mirror, force zero on a degenerate triangle
    assign axis_end = axis_t'(vbus_out[VBUS_W-1 -: 2]);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (fl_end.zero) begin
                nrm_next[k] = '0;
            end else if (fl_end.sgn[k] ^ (axis_end == axis_t'(2'(k + 1)))) begin
                nrm_next[k] = -coord_t'({1'b0, quot[k]});
            end else begin
                nrm_next[k] = coord_t'({1'b0, quot[k]});
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= div_valid[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {nrm_next[2], nrm_next[1], nrm_next[0],
                            vbus_out[NUM_VERT*COORD_W-1:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tnm_delay.sv
// ----------------------------------------------------------------------------
// Triangle normal and mirror: delay line
// Enable-gated shift register that keeps side data aligned with the pipe.
// ----------------------------------------------------------------------------
`default_nettype none

module tnm_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] sr_reg [DEPTH];

    // Advance the whole line on enable
    always_ff @(posedge aclk) begin
        if (en) begin
            sr_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    assign dout = sr_reg[DEPTH-1];

endmodule

`default_nettype wire

// File: hw/rtl/tnm_cross.sv
// ----------------------------------------------------------------------------
// Triangle normal and mirror: cross product
// Edge differences, six products, then the three component differences.
// ----------------------------------------------------------------------------
`default_nettype none

module tnm_cross
    import tnm_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire coord_t                    v [NUM_VERT],
    output logic                           out_valid,
    output logic signed [CROSS_W-1:0]      c [3]
);

    logic signed [EDGE_W-1:0]  a_reg [3];
    logic signed [EDGE_W-1:0]  b_reg [3];
    logic signed [PROD_W-1:0]  p_reg [6];
    logic signed [CROSS_W-1:0] c_reg [3];
    logic [CROSS_LAT-1:0]      vld_reg;

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[CROSS_LAT-2:0], in_valid};
        end
    end

    // Edges, products, differences
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                a_reg[k] <= EDGE_W'(v[3+k]) - EDGE_W'(v[k]);
                b_reg[k] <= EDGE_W'(v[6+k]) - EDGE_W'(v[k]);
            end
            p_reg[0] <= PROD_W'(a_reg[1]) * PROD_W'(b_reg[2]);
            p_reg[1] <= PROD_W'(a_reg[2]) * PROD_W'(b_reg[1]);
            p_reg[2] <= PROD_W'(a_reg[2]) * PROD_W'(b_reg[0]);
            p_reg[3] <= PROD_W'(a_reg[0]) * PROD_W'(b_reg[2]);
            p_reg[4] <= PROD_W'(a_reg[0]) * PROD_W'(b_reg[1]);
            p_reg[5] <= PROD_W'(a_reg[1]) * PROD_W'(b_reg[0]);
            for (int k = 0; k < 3; k++) begin
                c_reg[k] <= CROSS_W'(p_reg[2*k]) - CROSS_W'(p_reg[2*k+1]);
            end
        end
    end

    assign out_valid = vld_reg[CROSS_LAT-1];
    assign c         = c_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tnm_prep.sv
// ----------------------------------------------------------------------------
// Triangle normal and mirror: normalize prep
// Magnitudes, common leading-one position, shift to bit 29, sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module tnm_prep
    import tnm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic signed [CROSS_W-1:0] c [3],
    output logic                       out_valid,
    output logic [NORM_W-1:0]          m [3],
    output nrm_flags_t                 flags,
    output logic [SUM_W-1:0]           sum
);

    logic [PREP_LAT-1:0] vld_reg;

    logic [MAG_W-1:0]  mag1_reg [3];
    logic [MAG_W-1:0]  mag2_reg [3];
    logic [MAG_W-1:0]  or1_reg;
    logic [2:0]        sgn1_reg;
    logic [LEAD_W-1:0] lead_next;
    logic [LEAD_W-1:0] lead2_reg;
    nrm_flags_t        fl2_reg, fl3_reg, fl4_reg, fl5_reg;
    logic [NORM_W-1:0] m3_reg [3];
    logic [NORM_W-1:0] m4_reg [3];
    logic [NORM_W-1:0] m5_reg [3];
    logic [SQ_W-1:0]   sq4_reg [3];
    logic [SUM_W-1:0]  sum5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PREP_LAT-2:0], in_valid};
        end
    end

    // Highest set bit of the OR equals that of the largest magnitude
    always_comb begin
        lead_next = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (or1_reg[b]) begin
                lead_next = LEAD_W'(b);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Magnitudes and signs
            for (int k = 0; k < 3; k++) begin
                mag1_reg[k] <= c[k][CROSS_W-1] ? MAG_W'(-c[k]) : MAG_W'(c[k]);
                sgn1_reg[k] <= c[k][CROSS_W-1];
            end
            or1_reg <= MAG_W'(c[0][CROSS_W-1] ? -c[0] : c[0])
                     | MAG_W'(c[1][CROSS_W-1] ? -c[1] : c[1])
                     | MAG_W'(c[2][CROSS_W-1] ? -c[2] : c[2]);
            // Leading one
            mag2_reg      <= mag1_reg;
            lead2_reg     <= lead_next;
            fl2_reg.sgn   <= sgn1_reg;
            fl2_reg.zero  <= (or1_reg == '0);
            // Shift so the leading bit lands on bit 29
            for (int k = 0; k < 3; k++) begin
                m3_reg[k] <= NORM_W'({mag2_reg[k], {TOP_BIT{1'b0}}} >> lead2_reg);
            end
            fl3_reg <= fl2_reg;
            // Squares
            for (int k = 0; k < 3; k++) begin
                sq4_reg[k] <= SQ_W'(m3_reg[k]) * SQ_W'(m3_reg[k]);
            end
            m4_reg  <= m3_reg;
            fl4_reg <= fl3_reg;
            // Sum
            sum5_reg <= SUM_W'(sq4_reg[0]) + SUM_W'(sq4_reg[1]) + SUM_W'(sq4_reg[2]);
            m5_reg   <= m4_reg;
            fl5_reg  <= fl4_reg;
        end
    end

    assign out_valid = vld_reg[PREP_LAT-1];
    assign m         = m5_reg;
    assign flags     = fl5_reg;
    assign sum       = sum5_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tnm_sqrt.sv
// ----------------------------------------------------------------------------
// Triangle normal and mirror: integer square root
// Restoring digit recurrence, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tnm_sqrt
    import tnm_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [SUM_W-1:0] s,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     root
);

    logic [REM_W-1:0]  rem_reg  [SQRT_LAT];
    logic [ROOT_W-1:0] root_reg [SQRT_LAT];
    logic [SUM_W-1:0]  s_reg    [SQRT_LAT];
    logic [SQRT_LAT-1:0] vld_reg;

    for (genvar i = 0; i < SQRT_LAT; i++) begin : g_step
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SUM_W-1:0]  s_in;
        logic              vld_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              fit;

        if (i == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign s_in    = s;
            assign vld_in  = in_valid;
        end else begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign s_in    = s_reg[i-1];
            assign vld_in  = vld_reg[i-1];
        end

        // Bring down two bits and try the next root bit
        always_comb begin
            rem_sh = {rem_in[REM_W-3:0], s_in[SUM_W-1-2*i -: 2]};
            trial  = REM_W'({root_in, 2'b01});
            fit    = (rem_sh >= trial);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= fit ? (rem_sh - trial) : rem_sh;
                root_reg[i] <= {root_in[ROOT_W-2:0], fit};
                s_reg[i]    <= s_in;
            end
        end
    end

    assign out_valid = vld_reg[SQRT_LAT-1];
    assign root      = root_reg[SQRT_LAT-1];

endmodule

`default_nettype wire

// File: hw/rtl/tnm_div.sv
// ----------------------------------------------------------------------------
// Triangle normal and mirror: rounding divider
// Forms m * 2^14 + r/2, then restoring division, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tnm_div
    import tnm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [NORM_W-1:0] m,
    input  wire logic [ROOT_W-1:0] r,
    output logic                   out_valid,
    output logic [QUOT_W-1:0]      q
);

    logic [NUM_W-1:0]  n_reg;
    logic [ROOT_W-1:0] r0_reg;
    logic              v0_reg;

    logic [PART_W-1:0] p_reg  [QUOT_W];
    logic [QUOT_W-1:0] q_reg  [QUOT_W];
    logic [QUOT_W-1:0] lo_reg [QUOT_W];
    logic [ROOT_W-1:0] r_reg  [QUOT_W];
    logic [QUOT_W-1:0] vld_reg;

    // Rounded numerator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg  <= NUM_W'({m, {UNIT_SH{1'b0}}}) + NUM_W'(r >> 1);
            r0_reg <= r;
        end
    end

    for (genvar k = 0; k < QUOT_W; k++) begin : g_step
        logic [PART_W-1:0] p_in;
        logic [QUOT_W-1:0] q_in;
        logic [QUOT_W-1:0] lo_in;
        logic [ROOT_W-1:0] r_in;
        logic              vld_in;
        logic [PART_W:0]   p_sh;
        logic              fit;

        if (k == 0) begin : g_first
            assign p_in   = PART_W'(n_reg[NUM_W-1:QUOT_W]);
            assign q_in   = '0;
            assign lo_in  = n_reg[QUOT_W-1:0];
            assign r_in   = r0_reg;
            assign vld_in = v0_reg;
        end else begin : g_next
            assign p_in   = p_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign lo_in  = lo_reg[k-1];
            assign r_in   = r_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end

        // Shift in the next numerator bit and subtract when it fits
        always_comb begin
            p_sh = {p_in, lo_in[QUOT_W-1-k]};
            fit  = (p_sh >= (PART_W+1)'(r_in));
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                p_reg[k]  <= fit ? PART_W'(p_sh - (PART_W+1)'(r_in)) : PART_W'(p_sh);
                q_reg[k]  <= {q_in[QUOT_W-2:0], fit};
                lo_reg[k] <= lo_in;
                r_reg[k]  <= r_in;
            end
        end
    end

    assign out_valid = vld_reg[QUOT_W-1];
    assign q         = q_reg[QUOT_W-1];

endmodule

`default_nettype wire

// File: hw/rtl/tnm_checker.sv
// ----------------------------------------------------------------------------
// Triangle normal and mirror: port checker
// Watches the top-level ports for input and output handshake and result sanity.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_normal_and_mirror_macros.svh"

module tnm_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [191:0] m_tdata
);

    logic norm_ok;

    // Every normal component within one unit
    always_comb begin
        norm_ok = 1'b1;
        for (int k = 0; k < 3; k++) begin
            if (($signed(m_tdata[144 + 16*k +: 16]) < -16384) ||
                ($signed(m_tdata[144 + 16*k +: 16]) > 16384)) begin
                norm_ok = 1'b0;
            end
        end
    end

    // A held result stays offered
    `TNM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    // A held result keeps its payload
    `TNM_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
    // Nothing leaves right after reset
    `TNM_ASSERT_ALWAYS(a_reset_empty, !aresetn, !m_tvalid)
    // Normal components stay within one unit
    `TNM_ASSERT_NOW(a_norm_range, m_tvalid, norm_ok)
    // Input is held off only while a result waits at the output
    `TNM_ASSERT_NOW(a_in_stall, !s_tready, m_tvalid && !m_tready)

endmodule

bind triangle_normal_and_mirror tnm_checker u_tnm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: test/triangle_normal_and_mirror_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triangle normal and mirror: testbench
// Streams triangles with random bursts and output stalls, predicts the mirrored
// vertices and the Q1.14 unit normal per triangle, and checks every result.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_normal_and_mirror_tb;
    import tnm_pkg::*;

    localparam int LATENCY     = 56;
    localparam int NUM_RANDOM  = 1080;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [143:0] verts;
        axis_t        axis;
    } tri_t;

    // Expected results of accepted triangles, checked in order
    class normal_scoreboard;
        logic [191:0] pending[$];
        int           errors;

        function automatic logic [63:0] isqrt(input logic [63:0] s);
            logic [63:0] res;
            logic [63:0] b;
            res = 0;
            b   = 64'd1 << 62;
            while (b > s) b = b >> 2;
            while (b != 0) begin
                if (s >= res + b) begin
                    s   = s - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function automatic logic [191:0] face_normal(input tri_t t);
            longint v[3][3];
            longint c[3];
            longint nrm[3];
            logic [63:0] mag[3];
            logic [63:0] mx, s, r, q;
            int p, k;
            logic [191:0] res;
            for (int i = 0; i < 9; i++) begin
                v[i / 3][i % 3] = longint'($signed(t.verts[16*i +: 16]));
            end
            c[0] = (v[1][1]-v[0][1])*(v[2][2]-v[0][2]) - (v[1][2]-v[0][2])*(v[2][1]-v[0][1]);
            c[1] = (v[1][2]-v[0][2])*(v[2][0]-v[0][0]) - (v[1][0]-v[0][0])*(v[2][2]-v[0][2]);
            c[2] = (v[1][0]-v[0][0])*(v[2][1]-v[0][1]) - (v[1][1]-v[0][1])*(v[2][0]-v[0][0]);
            mx = 0;
            for (int i = 0; i < 3; i++) begin
                nrm[i] = 0;
                mag[i] = (c[i] < 0) ? -c[i] : c[i];
                if (mag[i] > mx) mx = mag[i];
            end
            // Scale so the leading bit lands on TOP_BIT, then divide by the root
            if (mx != 0) begin
                p = -1;
                for (int i = 0; i < 64; i++) if (mx[i]) p = i;
                s = 0;
                for (int i = 0; i < 3; i++) begin
                    if (p > TOP_BIT) mag[i] = mag[i] >> (p - TOP_BIT);
                    else mag[i] = mag[i] << (TOP_BIT - p);
                    s = s + mag[i] * mag[i];
                end
                r = isqrt(s);
                for (int i = 0; i < 3; i++) begin
                    q = (mag[i] * 64'd16384 + (r >> 1)) / r;
                    nrm[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
                end
            end
            // Mirror one axis, saturating the most negative coordinate
            if (t.axis != AXIS_NONE) begin
                k = int'(t.axis) - 1;
                for (int i = 0; i < 3; i++) begin
                    v[i][k] = (v[i][k] == -32768) ? 32767 : -v[i][k];
                end
                nrm[k] = -nrm[k];
            end
            for (int i = 0; i < 9; i++) res[16*i +: 16] = v[i / 3][i % 3][15:0];
            for (int i = 0; i < 3; i++) res[144 + 16*i +: 16] = nrm[i][15:0];
            return res;
        endfunction

        function void note_triangle(input tri_t t);
            pending.push_back(face_normal(t));
        endfunction

        function void check_result(input logic [191:0] got);
            logic [191:0] exp_val;
            string names[12] = '{"out0_x", "out0_y", "out0_z", "out1_x", "out1_y",
                "out1_z", "out2_x", "out2_y", "out2_z", "normal_x", "normal_y",
                "normal_z"};
            if (pending.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
                return;
            end
            exp_val = pending.pop_front();
            for (int i = 0; i < 12; i++) begin
                if (got[16*i +: 16] !== exp_val[16*i +: 16]) begin
                    $error("%s: expected %0d, actual %0d", names[i],
                        $signed(exp_val[16*i +: 16]), $signed(got[16*i +: 16]));
                    errors++;
                end
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;

    normal_scoreboard sb;
    tri_t             directed[$];
    bit               hold_long;
    bit               sender_done;
    int               idle_cycles;

    triangle_normal_and_mirror dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Offer one triangle and hold it until accepted
    task automatic send_triangle(input tri_t t);
        s_tvalid <= 1'b1;
        s_tdata  <= t.verts;
        s_tuser  <= t.axis;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_triangle(t);
    endtask

    task automatic drop_valid();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic tri_t make_triangle(input logic [15:0] c[9], input axis_t a);
        tri_t t;
        for (int i = 0; i < 9; i++) t.verts[16*i +: 16] = c[i];
        t.axis = a;
        return t;
    endfunction

    // Random coordinate: full range, small values, or the extremes
    function automatic logic [15:0] rand_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) return 16'($urandom());
        if (sel < 8) return 16'($signed($urandom_range(0, 512)) - 256);
        return (sel == 8) ? 16'h8000 : 16'h7fff;
    endfunction

    function automatic tri_t rand_triangle();
        logic [15:0] c[9];
        int kind;
        kind = $urandom_range(0, 19);
        for (int i = 0; i < 9; i++) c[i] = rand_coord();
        // Some degenerate ones: repeated vertex or collinear points
        if (kind == 0) for (int i = 0; i < 3; i++) c[3 + i] = c[i];
        if (kind == 1) for (int i = 0; i < 3; i++) c[6 + i] = c[3 + i];
        if (kind == 2) begin
            for (int i = 0; i < 3; i++) begin
                c[i]     = 16'($signed($urandom_range(0, 200)) - 100);
                c[3 + i] = c[i] + 16'(i + 3);
                c[6 + i] = c[i] + 16'(2 * (i + 3));
            end
        end
        return make_triangle(c, axis_t'($urandom_range(0, 3)));
    endfunction

    task automatic build_directed();
        logic [15:0] c[9];
        // Axis-aligned right triangle under every mirror
        c = '{16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000,
              16'h0000, 16'h0100, 16'h0000};
        for (int a = 0; a < 4; a++) directed.push_back(make_triangle(c, axis_t'(a)));
        // All zero: degenerate
        c = '{default: 16'h0000};
        directed.push_back(make_triangle(c, AXIS_X));
        // Most negative everywhere: degenerate, saturating mirror
        c = '{default: 16'h8000};
        for (int a = 1; a < 4; a++) directed.push_back(make_triangle(c, axis_t'(a)));
        c = '{default: 16'h7fff};
        directed.push_back(make_triangle(c, AXIS_Z));
        // Largest edges
        c = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
              16'h8000, 16'h7fff, 16'h8000};
        for (int a = 0; a < 4; a++) directed.push_back(make_triangle(c, axis_t'(a)));
        c = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
              16'h8000, 16'h8000, 16'h7fff};
        directed.push_back(make_triangle(c, AXIS_Y));
        // Smallest nonzero cross product and a mixed-sign one
        c = '{16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000,
              16'h0000, 16'h0001, 16'h0000};
        directed.push_back(make_triangle(c, AXIS_NONE));
        c = '{16'hffff, 16'h0001, 16'hfffe, 16'h0003, 16'hfffd, 16'h0005,
              16'hfff9, 16'h0002, 16'h0011};
        for (int a = 0; a < 4; a++) directed.push_back(make_triangle(c, axis_t'(a)));
        // Collinear: degenerate
        c = '{16'h0010, 16'h0020, 16'h0030, 16'h0020, 16'h0040, 16'h0060,
              16'h0030, 16'h0060, 16'h0090};
        directed.push_back(make_triangle(c, AXIS_Z));
    endtask

    // Stimulus
    initial begin
        int burst;
        sb          = new();
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        aresetn     <= 1'b0;
        hold_long   = 1'b0;
        sender_done = 1'b0;
        build_directed();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_triangle(directed[i]);
        drop_valid();

        // Back-pressure: receiver holds off while the sender keeps offering
        hold_long = 1'b1;
        for (int i = 0; i < 150; i++) send_triangle(rand_triangle());
        drop_valid();
        while (sb.pending.size() != 0) @(posedge aclk);
        @(posedge aclk);

        for (int n = 0; n < NUM_RANDOM; ) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < NUM_RANDOM; k++, n++) begin
                send_triangle(rand_triangle());
            end
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
        s_tvalid    <= 1'b0;
        sender_done = 1'b1;
    end

    // Receiver stalls: a long hold-off once, then a duty pattern of its own
    initial begin
        int phase;
        m_tready <= 1'b0;
        wait (aresetn);
        m_tready <= 1'b1;
        wait (hold_long);
        m_tready <= 1'b0;
        repeat (300) @(posedge aclk);
        phase = 0;
        forever begin
            @(posedge aclk);
            phase = (phase + 1) % 64;
            if (phase < 20) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    // Check results and watch for a hang
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Finish once every expected result is in
    initial begin
        wait (sender_done);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
